[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL that checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/fftm_pkg.sv]
// Package with the types, codes and twiddle table of the multidimensional FFT unit.
`timescale 1ns / 1ps
package fftm_pkg;

  localparam int MAX_LOG_POINTS = 10;
  localparam int MAX_DIMS       = 3;
  localparam int STORE_DEPTH    = 1 << MAX_LOG_POINTS;
  localparam int ROM_DEPTH      = 256;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  typedef logic [MAX_LOG_POINTS-1:0] addr_t;

  // Operation codes of an input word.
  typedef enum logic [1:0] {
    OP_LOAD      = 2'd0,
    OP_TRANSFORM = 2'd1,
    OP_READ      = 2'd2
  } op_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_DIM_COUNT    = 3'd0,
    CFG_LOG_OUTER    = 3'd1,
    CFG_LOG_MIDDLE   = 3'd2,
    CFG_LOG_INNER    = 3'd3,
    CFG_DIRECTION    = 3'd4
  } cfg_index_t;

  // Source of the word written into the store.
  typedef enum logic [2:0] {
    WR_SAMPLE,
    WR_READ,
    WR_HELD,
    WR_DIFF,
    WR_SUM
  } wr_sel_t;

  // Butterfly arithmetic steps.
  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_FIRST,
    MUL_SECOND,
    MUL_ROUND
  } mul_step_t;

  // Controller states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_READ,
    ST_DIM,
    ST_REV_SCAN,
    ST_SW_RA,
    ST_SW_RC,
    ST_SW_WA,
    ST_SW_WC,
    ST_REV_STEP,
    ST_BF_SCAN,
    ST_BF_RA,
    ST_BF_RB,
    ST_BF_M1,
    ST_BF_M2,
    ST_BF_M3,
    ST_BF_W2,
    ST_BF_W1,
    ST_BF_STEP,
    ST_DONE
  } state_t;

  typedef struct packed {
    addr_t     rd_addr;
    logic      wr_en;
    addr_t     wr_addr;
    wr_sel_t   wr_sel;
    logic      cap_b;
    logic      tw_load;
    addr_t     tw_phase;
    logic      dir;
    mul_step_t mul;
    logic      out_load;
    logic      out_mem;
    logic      out_status;
  } dp_cmd_t;

  typedef struct packed {
    logic out_full;
    logic out_ready;
  } dp_sts_t;

  // Q30 value to a Q15 magnitude with saturation.
  function automatic logic [14:0] q30_to_q15(longint v);
    longint t;
    t = v;
    if (t < 0) t = 0;
    if (t > (longint'(1) <<< 30)) t = longint'(1) <<< 30;
    t = (t + 16384) >>> 15;
    if (t > 32767) t = 32767;
    return 15'(t);
  endfunction

  // Cos and sin of the quarter-turn angle with table index qi, by a Taylor series.
  function automatic logic [29:0] trig_entry(int qi);
    logic [63:0] x, x2, ts, tc;
    longint ss, cs;
    x  = ((64'(qi) << 6) * TWO_PI_Q30) >> 16;
    x2 = (x * x) >> 30;
    ts = x;
    tc = 64'd1 << 30;
    ss = longint'(x);
    cs = longint'(1) <<< 30;
    ts = ((ts * x2) >> 30) / 64'd6;   tc = ((tc * x2) >> 30) / 64'd2;
    ss = ss - longint'(ts);           cs = cs - longint'(tc);
    ts = ((ts * x2) >> 30) / 64'd20;  tc = ((tc * x2) >> 30) / 64'd12;
    ss = ss + longint'(ts);           cs = cs + longint'(tc);
    ts = ((ts * x2) >> 30) / 64'd42;  tc = ((tc * x2) >> 30) / 64'd30;
    ss = ss - longint'(ts);           cs = cs - longint'(tc);
    ts = ((ts * x2) >> 30) / 64'd72;  tc = ((tc * x2) >> 30) / 64'd56;
    ss = ss + longint'(ts);           cs = cs + longint'(tc);
    ts = ((ts * x2) >> 30) / 64'd110; tc = ((tc * x2) >> 30) / 64'd90;
    ss = ss - longint'(ts);           cs = cs - longint'(tc);
    ts = ((ts * x2) >> 30) / 64'd156; tc = ((tc * x2) >> 30) / 64'd132;
    ss = ss + longint'(ts);           cs = cs + longint'(tc);
    ts = ((ts * x2) >> 30) / 64'd210; tc = ((tc * x2) >> 30) / 64'd182;
    ss = ss - longint'(ts);           cs = cs - longint'(tc);
    return {q30_to_q15(cs), q30_to_q15(ss)};
  endfunction

  typedef logic [29:0] trig_rom_t [ROM_DEPTH];

  function automatic trig_rom_t build_trig_rom();
    trig_rom_t rom;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      rom[i] = trig_entry(i);
    end
    return rom;
  endfunction

  // Quarter-wave table: cos in the upper 15 bits, sin in the lower 15 bits.
  localparam trig_rom_t TRIG_ROM = build_trig_rom();

endpackage

[hw/rtl/fftm_in_if.sv]
// Input channel: operation words with valid and ready.
`timescale 1ns / 1ps
interface fftm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [9:0]         element_index;
  logic signed [15:0] sample_real;
  logic signed [15:0] sample_imag;

  modport source (output valid, operation, element_index, sample_real, sample_imag,
                  input ready);
  modport sink   (input valid, operation, element_index, sample_real, sample_imag,
                  output ready);
endinterface

[hw/rtl/fftm_out_if.sv]
// Result channel: one result word per operation, with valid and ready.
`timescale 1ns / 1ps
interface fftm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value_real;
  logic signed [31:0] value_imag;
  logic               status;

  modport source (output valid, value_real, value_imag, status, input ready);
  modport sink   (input valid, value_real, value_imag, status, output ready);
endinterface

[hw/rtl/fftm_cfg_if.sv]
// Configuration write channel: register index and data with valid and ready.
`timescale 1ns / 1ps
interface fftm_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [3:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/multidim_radix2_fft_in_place_unit.sv]
// Top level of the in-place multidimensional radix-2 FFT unit.
//
//   Channel   Dir  Payload
//   in_bus    in   operation, element_index, sample_real, sample_imag
//   out_bus   out  value_real, value_imag, status
//   cfg_bus   in   index, data (register write)
//
// A load, an unused code, a transform with a size error or with no dimensions gives
// its result in the cycle after acceptance; a read first passes through ST_READ.
// A transform takes, per dimension of log length s > 0, a setup state, the
// bit-reversal reordering and s butterfly stages; a dimension of length one takes
// only its setup state, and a final state posts the result. All of it goes through
// the store's one write port and one read port and one shared multiplier pair.
// Reset is synchronous, active low; the store keeps no reset value.
// A new word is taken while idle and the result register is free or being taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module multidim_radix2_fft_in_place_unit (
  input logic        clk,
  input logic        rst_n,
  fftm_in_if.sink    in_bus,
  fftm_out_if.source out_bus,
  fftm_cfg_if.sink   cfg_bus
);
  import fftm_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;
  logic    load_take;
  logic    read_take;

  fftm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .cfg_bus (cfg_bus),
    .sts     (dp_sts),
    .cmd     (dp_cmd)
  );

  fftm_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (dp_cmd),
    .sample_real (in_bus.sample_real),
    .sample_imag (in_bus.sample_imag),
    .sts         (dp_sts),
    .out_bus     (out_bus)
  );

  // Accepted loads and reads.
  assign load_take = in_bus.valid && in_bus.ready && in_bus.operation == OP_LOAD;
  assign read_take = in_bus.valid && in_bus.ready && in_bus.operation == OP_READ;

  // A load shows its result in the next cycle.
  `ASSERT_NEXT(a_load_result, clk, rst_n, load_take, out_bus.valid)
  // A read needs the store latency before its result appears.
  `ASSERT_NEXT(a_read_latency, clk, rst_n, read_take, !out_bus.valid)
  // The store is written while open for input only by a load.
  `ASSERT_IMPLIES(a_quiet_writes, clk, rst_n, dp_cmd.wr_en && in_bus.ready, load_take)
endmodule

[hw/rtl/fftm_dp.sv]
// Datapath: sample store, twiddle lookup, butterfly arithmetic and result register.
`timescale 1ns / 1ps
module fftm_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  fftm_pkg::dp_cmd_t  cmd,
  input  logic signed [15:0] sample_real,
  input  logic signed [15:0] sample_imag,
  output fftm_pkg::dp_sts_t  sts,
  fftm_out_if.source         out_bus
);
  import fftm_pkg::*;

  logic [63:0] mem [STORE_DEPTH];
  logic [63:0] rd_r;
  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [63:0] wr_data;

  logic signed [16:0] wr_r, wi_r, wr_nxt, wi_nxt;
  logic signed [16:0] cos_v, sin_v;
  logic [29:0]        rom_word;

  logic signed [48:0] p0_r, p1_r;
  logic [31:0]        tr_r, ti_r;
  logic signed [31:0] b_re, b_im;

  logic               out_valid_r;
  logic [31:0]        out_re_r, out_im_r;
  logic               out_status_r;

  // Round a product sum back to the word scale.
  function automatic logic [31:0] rnd15(logic signed [49:0] v);
    logic signed [49:0] t;
    t = v + 50'sd16384;
    return t[46:15];
  endfunction

  // Store write mux.
  always_comb begin
    case (cmd.wr_sel)
      WR_SAMPLE: wr_data = {{16{sample_real[15]}}, sample_real,
                            {16{sample_imag[15]}}, sample_imag};
      WR_READ:   wr_data = rd_r;
      WR_HELD:   wr_data = b_r;
      WR_DIFF:   wr_data = {a_r[63:32] - tr_r, a_r[31:0] - ti_r};
      WR_SUM:    wr_data = {a_r[63:32] + tr_r, a_r[31:0] + ti_r};
      default:   wr_data = rd_r;
    endcase
  end

  // Sample store with one write and one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= wr_data;
    end
    rd_r <= mem[cmd.rd_addr];
  end

  // Twiddle from the quarter-wave table, folded by quadrant.
  always_comb begin
    rom_word = TRIG_ROM[cmd.tw_phase[7:0]];
    cos_v    = {2'b00, rom_word[29:15]};
    sin_v    = {2'b00, rom_word[14:0]};
    case (cmd.tw_phase[9:8])
      2'd0:    begin wr_nxt = cos_v;  wi_nxt = sin_v;  end
      2'd1:    begin wr_nxt = -sin_v; wi_nxt = cos_v;  end
      2'd2:    begin wr_nxt = -cos_v; wi_nxt = -sin_v; end
      default: begin wr_nxt = sin_v;  wi_nxt = -cos_v; end
    endcase
    if (cmd.dir) begin
      wi_nxt = -wi_nxt;
    end
  end

  assign b_re = b_r[63:32];
  assign b_im = b_r[31:0];

  // Butterfly operand capture and products.
  always_ff @(posedge clk) begin
    if (cmd.tw_load) begin
      wr_r <= wr_nxt;
      wi_r <= wi_nxt;
    end
    if (cmd.cap_b) begin
      b_r <= rd_r;
    end
    case (cmd.mul)
      MUL_FIRST: begin
        a_r  <= rd_r;
        p0_r <= wr_r * b_re;
        p1_r <= wi_r * b_im;
      end
      MUL_SECOND: begin
        tr_r <= rnd15(50'(p0_r) - 50'(p1_r));
        p0_r <= wr_r * b_im;
        p1_r <= wi_r * b_re;
      end
      MUL_ROUND: begin
        ti_r <= rnd15(50'(p0_r) + 50'(p1_r));
      end
      default: begin
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_re_r     <= cmd.out_mem ? rd_r[63:32] : 32'd0;
      out_im_r     <= cmd.out_mem ? rd_r[31:0] : 32'd0;
      out_status_r <= cmd.out_status;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.value_real = out_re_r;
  assign out_bus.value_imag = out_im_r;
  assign out_bus.status     = out_status_r;

  assign sts.out_full  = out_valid_r;
  assign sts.out_ready = out_bus.ready;
endmodule

[hw/rtl/fftm_ctrl.sv]
// Controller: configuration registers and the sequencer for load, read and transform.
`timescale 1ns / 1ps
module fftm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  fftm_in_if.sink           in_bus,
  fftm_cfg_if.sink          cfg_bus,
  input  fftm_pkg::dp_sts_t sts,
  output fftm_pkg::dp_cmd_t cmd
);
  import fftm_pkg::*;

  state_t     state_r, state_nxt;
  logic [1:0] di_r, di_nxt;
  logic [3:0] pre_r, pre_nxt;
  logic [3:0] lg_r, lg_nxt;
  addr_t      cnt_r, cnt_nxt;

  logic [1:0] dim_count_r;
  logic [3:0] log_outer_r, log_middle_r, log_inner_r;
  logic       dir_r;

  logic [1:0] dims;
  logic [5:0] total;
  logic       err;
  logic [3:0] s_cur;
  addr_t      last;
  addr_t      nmask, j_field, j_rev_full, j_rev, c_addr;
  logic       swap_need;
  logic [3:0] bitpos;
  addr_t      hbit, k2_addr, hmask, m_val, phase;
  logic       upper_half;
  logic       in_ready;

  // Configuration registers; writes must arrive only while idle: the user is bound, the block does not enforce it.
  assign cfg_bus.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_count_r  <= 2'd2;
      log_outer_r  <= 4'd5;
      log_middle_r <= 4'd5;
      log_inner_r  <= 4'd0;
      dir_r        <= 1'b0;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        CFG_DIM_COUNT:  dim_count_r  <= cfg_bus.data[1:0];
        CFG_LOG_OUTER:  log_outer_r  <= cfg_bus.data;
        CFG_LOG_MIDDLE: log_middle_r <= cfg_bus.data;
        CFG_LOG_INNER:  log_inner_r  <= cfg_bus.data;
        CFG_DIRECTION:  dir_r        <= cfg_bus.data[0];
        default: begin
        end
      endcase
    end
  end

  // Size check and per-dimension address fields.
  always_comb begin
    dims  = (dim_count_r > 2'(MAX_DIMS)) ? 2'(MAX_DIMS) : dim_count_r;
    total = ((dims > 2'd0) ? 6'(log_outer_r) : 6'd0)
          + ((dims > 2'd1) ? 6'(log_middle_r) : 6'd0)
          + ((dims > 2'd2) ? 6'(log_inner_r) : 6'd0);
    err   = total > 6'(MAX_LOG_POINTS);
    case (di_r)
      2'd0:    s_cur = log_outer_r;
      2'd1:    s_cur = log_middle_r;
      2'd2:    s_cur = log_inner_r;
      default: s_cur = 4'd0;
    endcase
    last    = addr_t'((11'd1 << total) - 11'd1);
    nmask   = addr_t'((11'd1 << s_cur) - 11'd1);
    j_field = addr_t'(cnt_r >> pre_r) & nmask;
    for (int b = 0; b < MAX_LOG_POINTS; b++) begin
      j_rev_full[b] = j_field[MAX_LOG_POINTS-1-b];
    end
    j_rev     = j_rev_full >> (4'(MAX_LOG_POINTS) - s_cur);
    c_addr    = (cnt_r & ~(nmask << pre_r)) | addr_t'(j_rev << pre_r);
    swap_need = j_field < j_rev;
    // Butterfly partner and twiddle phase for the current stage.
    bitpos     = pre_r + lg_r - 4'd1;
    hbit       = addr_t'(1) << bitpos;
    k2_addr    = cnt_r | hbit;
    upper_half = |(cnt_r & hbit);
    hmask      = addr_t'((11'd1 << (lg_r - 4'd1)) - 11'd1);
    m_val      = j_field & hmask;
    phase      = addr_t'(m_val << (4'(MAX_LOG_POINTS) - lg_r));
  end

  // State and loop registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      di_r    <= 2'd0;
      pre_r   <= 4'd0;
      lg_r    <= 4'd0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      di_r    <= di_nxt;
      pre_r   <= pre_nxt;
      lg_r    <= lg_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt      = state_r;
    di_nxt         = di_r;
    pre_nxt        = pre_r;
    lg_nxt         = lg_r;
    cnt_nxt        = cnt_r;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.dir        = dir_r;
    cmd.tw_phase   = phase;
    cmd.out_status = err;
    case (state_r)
      ST_IDLE: begin
        in_ready    = !sts.out_full || sts.out_ready;
        cmd.rd_addr = in_bus.element_index;
        if (in_bus.valid && in_ready) begin
          case (in_bus.operation)
            OP_LOAD: begin
              cmd.wr_en    = 1'b1;
              cmd.wr_addr  = in_bus.element_index;
              cmd.wr_sel   = WR_SAMPLE;
              cmd.out_load = 1'b1;
            end
            OP_READ: begin
              state_nxt = ST_READ;
            end
            OP_TRANSFORM: begin
              if (err || dims == 2'd0) begin
                cmd.out_load = 1'b1;
              end else begin
                di_nxt    = dims - 2'd1;
                pre_nxt   = 4'd0;
                state_nxt = ST_DIM;
              end
            end
            default: begin
              cmd.out_load = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        cmd.out_load = 1'b1;
        cmd.out_mem  = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_DIM: begin
        cnt_nxt = '0;
        if (s_cur == 4'd0) begin
          if (di_r == 2'd0) begin
            state_nxt = ST_DONE;
          end else begin
            di_nxt    = di_r - 2'd1;
            state_nxt = ST_DIM;
          end
        end else begin
          state_nxt = ST_REV_SCAN;
        end
      end
      // Bit-reversal reordering: one swap per index pair.
      ST_REV_SCAN: begin
        state_nxt = swap_need ? ST_SW_RA : ST_REV_STEP;
      end
      ST_SW_RA: begin
        cmd.rd_addr = cnt_r;
        state_nxt   = ST_SW_RC;
      end
      ST_SW_RC: begin
        cmd.rd_addr = c_addr;
        cmd.cap_b   = 1'b1;
        state_nxt   = ST_SW_WA;
      end
      ST_SW_WA: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = cnt_r;
        cmd.wr_sel  = WR_READ;
        state_nxt   = ST_SW_WC;
      end
      ST_SW_WC: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = c_addr;
        cmd.wr_sel  = WR_HELD;
        state_nxt   = ST_REV_STEP;
      end
      ST_REV_STEP: begin
        if (cnt_r == last) begin
          cnt_nxt   = '0;
          lg_nxt    = 4'd1;
          state_nxt = ST_BF_SCAN;
        end else begin
          cnt_nxt   = cnt_r + addr_t'(1);
          state_nxt = ST_REV_SCAN;
        end
      end
      // Butterflies: the lower index of each pair leads.
      ST_BF_SCAN: begin
        state_nxt = upper_half ? ST_BF_STEP : ST_BF_RA;
      end
      ST_BF_RA: begin
        cmd.rd_addr = k2_addr;
        cmd.tw_load = 1'b1;
        state_nxt   = ST_BF_RB;
      end
      ST_BF_RB: begin
        cmd.rd_addr = cnt_r;
        cmd.cap_b   = 1'b1;
        state_nxt   = ST_BF_M1;
      end
      ST_BF_M1: begin
        cmd.mul   = MUL_FIRST;
        state_nxt = ST_BF_M2;
      end
      ST_BF_M2: begin
        cmd.mul   = MUL_SECOND;
        state_nxt = ST_BF_M3;
      end
      ST_BF_M3: begin
        cmd.mul   = MUL_ROUND;
        state_nxt = ST_BF_W2;
      end
      ST_BF_W2: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = k2_addr;
        cmd.wr_sel  = WR_DIFF;
        state_nxt   = ST_BF_W1;
      end
      ST_BF_W1: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = cnt_r;
        cmd.wr_sel  = WR_SUM;
        state_nxt   = ST_BF_STEP;
      end
      ST_BF_STEP: begin
        if (cnt_r == last) begin
          cnt_nxt = '0;
          if (lg_r == s_cur) begin
            pre_nxt = pre_r + s_cur;
            if (di_r == 2'd0) begin
              state_nxt = ST_DONE;
            end else begin
              di_nxt    = di_r - 2'd1;
              state_nxt = ST_DIM;
            end
          end else begin
            lg_nxt    = lg_r + 4'd1;
            state_nxt = ST_BF_SCAN;
          end
        end else begin
          cnt_nxt   = cnt_r + addr_t'(1);
          state_nxt = ST_BF_SCAN;
        end
      end
      ST_DONE: begin
        cmd.out_load = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_bus.ready = in_ready;
endmodule
